FILE: design/rrsp_pkg.sv
package rrsp_pkg;

	localparam int SLOTS      = 64;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int ADDR_W     = 48;
	localparam int SIZE_W     = 25;
	localparam int OUT_SLOT_W = 6;
	localparam int CMD_W      = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

	localparam logic [SIZE_W-1:0] SLOT_SIZE_RESET = 25'd65536;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic                  ok;
		logic [ADDR_W-1:0]     region_base;
		logic [OUT_SLOT_W-1:0] slot;
	} rsp_t;

endpackage

FILE: design/round_robin_slot_pool_unit.sv
// Slot pool of SLOTS regions of slot_size bytes each. One command is worked at a time and
// req_ready is low while it runs. Alloc probes one slot per cycle from the round-robin
// pointer, then the done state loads the response register once the output can take it.
// Locate and free scan slots 0 upward, one per cycle through the single read port of the
// base memory, comparing each slot after its registered read. Alloc of base zero, locate
// above the end mark and an unused command go straight to the done state. Zero slot_size
// acts as one; slot_size must be written via the cfg port while idle, which is unchecked.
module round_robin_slot_pool_unit import rrsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	logic [1:0]        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] key_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] next_q;
	logic [ADDR_W-1:0] mark_q;
	logic [SIZE_W-1:0] size_q;
	logic [SLOTS-1:0]  valid_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              issued_s1;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic [ADDR_W-1:0] rd_base;
	logic              hit;
	logic              ram_we;
	logic [ADDR_W:0]   end_sum;
	logic [ADDR_W-1:0] end_sat;
	logic [SLOT_W-1:0] idx_inc;

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_inc = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign ram_we  = (state_q == ST_ALLOC) && !valid_q[idx_q];

	// last byte of the new region, saturated at the top of the address space
	assign end_sum = {1'b0, key_q} + (ADDR_W + 1)'(size_q) - 1'b1;
	assign end_sat = end_sum[ADDR_W] ? '1 : end_sum[ADDR_W-1:0];

	rrsp_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(SLOTS)
	) u_base_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(key_q),
		.raddr(idx_q),
		.rdata(rd_base)
	);

	rrsp_match u_match (
		.cmd (cmd_q),
		.key (key_q),
		.base(rd_base),
		.size(size_q),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SLOT_SIZE_RESET;
		end else if (cfg_valid) begin
			size_q <= (cfg_data == '0) ? SIZE_W'(1) : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			next_q      <= '0;
			mark_q      <= '0;
			rsp_valid_q <= 1'b0;
			issued_s1   <= 1'b0;
		end else begin
			// the done state loads the next beat itself
			if (rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q     <= req.cmd;
						key_q     <= req.address;
						res_q     <= '0;
						cnt_q     <= '0;
						issued_s1 <= 1'b0;
						case (req.cmd)
							CMD_ALLOC: begin
								idx_q   <= next_q;
								state_q <= (req.address == '0) ? ST_DONE : ST_ALLOC;
							end
							CMD_LOCATE: begin
								idx_q   <= '0;
								state_q <= (req.address > mark_q) ? ST_DONE : ST_SCAN;
							end
							CMD_FREE: begin
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_ALLOC: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						next_q         <= idx_inc;
						if (end_sat > mark_q) begin
							mark_q <= end_sat;
						end
						res_q   <= '{ok: 1'b1, region_base: key_q, slot: OUT_SLOT_W'(idx_q)};
						state_q <= ST_DONE;
					end else if (cnt_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_inc;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					// read of slot idx_q goes out now, its compare runs next cycle
					idx_q     <= idx_inc;
					idx_s1    <= idx_q;
					vld_s1    <= valid_q[idx_q];
					issued_s1 <= 1'b1;
					if (issued_s1 && vld_s1 && hit) begin
						if (cmd_q == CMD_FREE) begin
							valid_q[idx_s1] <= 1'b0;
						end
						res_q   <= '{ok: 1'b1, region_base: rd_base, slot: OUT_SLOT_W'(idx_s1)};
						state_q <= ST_DONE;
					end else if (issued_s1 && idx_s1 == LAST_IDX) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/rrsp_ram.sv
module rrsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/rrsp_match.sv
module rrsp_match import rrsp_pkg::*; (
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ADDR_W-1:0] key,
	input  logic [ADDR_W-1:0] base,
	input  logic [SIZE_W-1:0] size,
	output logic              hit
);

	logic [ADDR_W:0] diff;

	// key - base without borrow and below size means key lies in [base, base + size)
	assign diff = {1'b0, key} - {1'b0, base};

	always_comb begin
		case (cmd)
			CMD_LOCATE: hit = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(size));
			CMD_FREE:   hit = (key == base);
			default:    hit = 1'b0;
		endcase
	end

endmodule
